@@ hw/rtl/xmcr_pkg.sv @@
// Shared types and constants of the XMODEM checksum receiver.
// Used by the payload RAM, the output stage and the top level.
package xmcr_pkg;

  // Packet geometry
  localparam int unsigned PAYLOAD_BYTES = 128;
  localparam int unsigned WORD_BYTES    = 8;
  localparam int unsigned WORDS         = PAYLOAD_BYTES / WORD_BYTES;
  localparam int unsigned WORD_AW       = $clog2(WORDS);
  localparam int unsigned LANE_W        = $clog2(WORD_BYTES);

  // Byte positions inside a packet (after SOH)
  localparam logic [7:0] IDX_BLOCK     = 8'd0;
  localparam logic [7:0] IDX_DATA_LO   = 8'd2;
  localparam logic [7:0] IDX_DATA_END  = 8'(PAYLOAD_BYTES + 2);
  localparam logic [7:0] PKT_LEN       = 8'(PAYLOAD_BYTES + 3);
  localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(WORDS - 1);

  // Protocol bytes
  localparam logic [7:0] B_SOH = 8'h01;
  localparam logic [7:0] B_EOT = 8'h04;
  localparam logic [7:0] B_ACK = 8'h06;
  localparam logic [7:0] B_NAK = 8'h15;
  localparam logic [7:0] B_CAN = 8'h18;

  // Input operation codes
  localparam logic [1:0] OP_BYTE  = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;

  // Result kind and session end codes
  localparam logic       KIND_DATA  = 1'b0;
  localparam logic       KIND_REPLY = 1'b1;
  localparam logic [1:0] END_NONE   = 2'd0;
  localparam logic [1:0] END_DONE   = 2'd1;
  localparam logic [1:0] END_ABORT  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_TIMEOUT_RELOAD = 2'd0;
  localparam logic [1:0] REG_START_RETRIES  = 2'd1;
  localparam logic [1:0] REG_PACKET_RETRIES = 2'd2;
  localparam logic [1:0] REG_MAX_FAILURES   = 2'd3;

  // Configuration reset values
  localparam logic [15:0] RST_TIMEOUT_RELOAD = 16'd1000;
  localparam logic [7:0]  RST_START_RETRIES  = 8'd60;
  localparam logic [7:0]  RST_PACKET_RETRIES = 8'd10;
  localparam logic [7:0]  RST_MAX_FAILURES   = 8'd10;

  // Control sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SEND,
    S_REPLY
  } xmcr_state_t;

  // One result word
  typedef struct packed {
    logic        last;
    logic [1:0]  session_end;
    logic [7:0]  reply_byte;
    logic [63:0] data_word;
    logic        kind;
  } xmcr_result_t;

endpackage

@@ hw/rtl/xmcr_payload_ram.sv @@
// Payload store of the XMODEM checksum receiver: 16 x 64-bit words with
// byte write enables and a registered read port. Depends on xmcr_pkg.
module xmcr_payload_ram
  import xmcr_pkg::*;
(
  input  logic                  clk,
  input  logic                  we,
  input  logic [WORD_BYTES-1:0] be,
  input  logic [WORD_AW-1:0]    waddr,
  input  logic [63:0]           wdata,
  input  logic                  re,
  input  logic [WORD_AW-1:0]    raddr,
  output logic [63:0]           rdata
);

  logic [63:0] mem [WORDS];
  logic [63:0] rdata_r;

  // Write the enabled byte lanes
  always_ff @(posedge clk) begin
    if (we) begin
      for (int j = 0; j < WORD_BYTES; j++) begin
        if (be[j]) begin
          mem[waddr][j*8 +: 8] <= wdata[j*8 +: 8];
        end
      end
    end
  end

  // Registered read, held between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/xmcr_out_stage.sv @@
// Output register of the XMODEM checksum receiver: holds one result word
// until the downstream side takes it. Depends on xmcr_pkg.
module xmcr_out_stage
  import xmcr_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  xmcr_result_t push_data,
  output logic         can_accept,
  output logic         out_valid,
  input  logic         out_ready,
  output xmcr_result_t out_data
);

  logic         valid_r;
  logic         valid_nxt;
  xmcr_result_t data_r;

  // Free when empty or when the held word leaves this cycle
  assign can_accept = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (push) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  // Hold the valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Load the payload on push
  always_ff @(posedge clk) begin
    if (push) begin
      data_r <= push_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

@@ hw/rtl/xmodem_checksum_receiver.sv @@
// Top level of the XMODEM checksum receiver: session control, packet
// collector and payload drain. Depends on xmcr_pkg, xmcr_payload_ram, xmcr_out_stage.
// Usage:
//   Input stream: in_tuser carries the operation (byte, tick, start), in_tdata
//   the received byte. Output stream: in_tuser-like out_tuser gives the kind
//   (payload word or reply byte), out_tdata the word, the reply byte and the
//   session end code, out_tlast marks the final word caused by one input.
//   cfg_we writes one of four registers (timeout reload, start retries, packet
//   retries, max failures) only while idle: a user rule the block does not enforce.
// Timing:
//   An input word is taken while the block is idle. A reply that cannot enter
//   the output register at once is parked, and no input is taken until it is
//   pushed. A good packet's checksum byte starts a drain of sixteen payload
//   words, each a payload RAM read and then a push into the output register,
//   which waits while that register is full; then the ACK. No input is taken
//   during the drain. The payload RAM is written only while idle and read only
//   during the drain, so a read never meets a write to the same word.
// Reset: rst_n clears the session state and loads the register defaults; the
//   payload RAM is not cleared. A stalled out_tready holds the result in the
//   output register; input is taken until another result needs that register.
module xmodem_checksum_receiver
  import xmcr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic [1:0]  in_tuser,   // [1:0] op
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // [63:0] data_word, [71:64] reply_byte,
                                  // [73:72] session_end, [79:74] zero
  output logic        out_tuser,  // [0] kind
  output logic        out_tlast,
  // Configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  // Configuration registers
  logic [15:0] timeout_reload_r;
  logic [7:0]  start_retries_r;
  logic [7:0]  packet_retries_r;
  logic [7:0]  max_failures_r;

  // Session state
  xmcr_state_t     state_r, state_nxt;
  logic            receiving_r, receiving_nxt;
  logic            in_packet_r, in_packet_nxt;
  logic [7:0]      byte_index_r, byte_index_nxt;
  logic [7:0]      expected_block_r, expected_block_nxt;
  logic [7:0]      running_sum_r, running_sum_nxt;
  logic [15:0]     timeout_left_r, timeout_left_nxt;
  logic [7:0]      retries_left_r, retries_left_nxt;
  logic [7:0]      failure_count_r, failure_count_nxt;
  logic [7:0]      block_number_r, block_number_nxt;
  logic [WORD_AW-1:0] word_idx_r, word_idx_nxt;

  // Pending reply (payload registers)
  logic [7:0] pend_reply_r, pend_reply_nxt;
  logic [1:0] pend_end_r, pend_end_nxt;

  // Datapath signals
  logic         in_acc;
  logic [1:0]   op;
  logic [7:0]   rx_b;
  logic [7:0]   idx_plus;
  logic [7:0]   data_pos;
  logic [7:0]   fail_inc;
  logic         reply_req;
  logic [7:0]   reply_code;
  logic [1:0]   reply_end;
  logic         push;
  xmcr_result_t push_data;
  logic         can_accept;
  xmcr_result_t out_res;
  logic         ram_we;
  logic [WORD_BYTES-1:0] ram_be;
  logic         ram_re;
  logic [63:0]  ram_rdata;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign op        = in_tuser;
  assign rx_b      = in_tdata;
  assign idx_plus  = byte_index_r + 8'd1;
  assign data_pos  = byte_index_r - IDX_DATA_LO;
  assign fail_inc  = (failure_count_r == 8'hFF) ? failure_count_r : failure_count_r + 8'd1;

  // One-hot lane of the payload byte inside its word
  always_comb begin
    ram_be = '0;
    ram_be[data_pos[LANE_W-1:0]] = 1'b1;
  end

  // Sequencer: process one input word, drain a good packet, send replies
  always_comb begin
    state_nxt          = state_r;
    receiving_nxt      = receiving_r;
    in_packet_nxt      = in_packet_r;
    byte_index_nxt     = byte_index_r;
    expected_block_nxt = expected_block_r;
    running_sum_nxt    = running_sum_r;
    timeout_left_nxt   = timeout_left_r;
    retries_left_nxt   = retries_left_r;
    failure_count_nxt  = failure_count_r;
    block_number_nxt   = block_number_r;
    word_idx_nxt       = word_idx_r;
    pend_reply_nxt     = pend_reply_r;
    pend_end_nxt       = pend_end_r;
    reply_req          = 1'b0;
    reply_code         = B_ACK;
    reply_end          = END_NONE;
    push               = 1'b0;
    push_data          = '0;
    ram_we             = 1'b0;
    ram_re             = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (op == OP_START) begin
            receiving_nxt      = 1'b1;
            timeout_left_nxt   = timeout_reload_r;
            retries_left_nxt   = start_retries_r;
            expected_block_nxt = 8'd1;
          end else if (receiving_r && op == OP_BYTE) begin
            if (in_packet_r) begin
              // Collect block number, payload and checksum
              if (byte_index_r == IDX_BLOCK) begin
                block_number_nxt = rx_b;
              end else if (byte_index_r >= IDX_DATA_LO && byte_index_r < IDX_DATA_END) begin
                ram_we          = 1'b1;
                running_sum_nxt = running_sum_r + rx_b;
              end
              if (idx_plus < PKT_LEN) begin
                byte_index_nxt = idx_plus;
              end else begin
                in_packet_nxt  = 1'b0;
                byte_index_nxt = 8'd0;
                if (block_number_r == expected_block_r && running_sum_r == rx_b) begin
                  expected_block_nxt = expected_block_r + 8'd1;
                  failure_count_nxt  = 8'd0;
                  word_idx_nxt       = '0;
                  state_nxt          = S_READ;
                end else begin
                  reply_req  = 1'b1;
                  reply_code = B_NAK;
                end
              end
            end else begin
              byte_index_nxt = 8'd0;
              if (rx_b == B_SOH) begin
                in_packet_nxt    = 1'b1;
                timeout_left_nxt = timeout_reload_r;
                retries_left_nxt = packet_retries_r;
                running_sum_nxt  = 8'd0;
              end else if (rx_b == B_EOT || rx_b == B_CAN) begin
                receiving_nxt      = 1'b0;
                in_packet_nxt      = 1'b0;
                expected_block_nxt = 8'd0;
                running_sum_nxt    = 8'd0;
                timeout_left_nxt   = 16'd0;
                retries_left_nxt   = 8'd0;
                failure_count_nxt  = 8'd0;
                block_number_nxt   = 8'd0;
                reply_req          = 1'b1;
                reply_code         = B_ACK;
                reply_end          = END_DONE;
              end
            end
          end else if (receiving_r && op == OP_TICK) begin
            // Count down the timeout; on expiry count a failure, or abort with CAN at the limit
            if (timeout_left_r != 16'd0) begin
              timeout_left_nxt = timeout_left_r - 16'd1;
            end else if (fail_inc >= max_failures_r) begin
              receiving_nxt      = 1'b0;
              in_packet_nxt      = 1'b0;
              byte_index_nxt     = 8'd0;
              expected_block_nxt = 8'd0;
              running_sum_nxt    = 8'd0;
              timeout_left_nxt   = 16'd0;
              retries_left_nxt   = 8'd0;
              failure_count_nxt  = 8'd0;
              block_number_nxt   = 8'd0;
              reply_req          = 1'b1;
              reply_code         = B_CAN;
              reply_end          = END_ABORT;
            end else begin
              failure_count_nxt = fail_inc;
              timeout_left_nxt  = timeout_reload_r;
              if (retries_left_r != 8'd0) begin
                retries_left_nxt = retries_left_r - 8'd1;
              end else begin
                receiving_nxt = 1'b0;
                in_packet_nxt = 1'b0;
              end
            end
          end
          // Push the reply now or park it
          if (reply_req) begin
            if (can_accept) begin
              push                  = 1'b1;
              push_data.kind        = KIND_REPLY;
              push_data.reply_byte  = reply_code;
              push_data.session_end = reply_end;
              push_data.last        = 1'b1;
            end else begin
              pend_reply_nxt = reply_code;
              pend_end_nxt   = reply_end;
              state_nxt      = S_REPLY;
            end
          end
        end
      end
      S_READ: begin
        ram_re    = 1'b1;
        state_nxt = S_SEND;
      end
      S_SEND: begin
        if (can_accept) begin
          push                = 1'b1;
          push_data.kind      = KIND_DATA;
          push_data.data_word = ram_rdata;
          if (word_idx_r == LAST_WORD) begin
            pend_reply_nxt = B_ACK;
            pend_end_nxt   = END_NONE;
            state_nxt      = S_REPLY;
          end else begin
            word_idx_nxt = word_idx_r + 1'b1;
            state_nxt    = S_READ;
          end
        end
      end
      S_REPLY: begin
        if (can_accept) begin
          push                  = 1'b1;
          push_data.kind        = KIND_REPLY;
          push_data.reply_byte  = pend_reply_r;
          push_data.session_end = pend_end_r;
          push_data.last        = 1'b1;
          state_nxt             = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      receiving_r      <= 1'b0;
      in_packet_r      <= 1'b0;
      byte_index_r     <= 8'd0;
      expected_block_r <= 8'd0;
      running_sum_r    <= 8'd0;
      timeout_left_r   <= 16'd0;
      retries_left_r   <= 8'd0;
      failure_count_r  <= 8'd0;
      block_number_r   <= 8'd0;
      word_idx_r       <= '0;
    end else begin
      state_r          <= state_nxt;
      receiving_r      <= receiving_nxt;
      in_packet_r      <= in_packet_nxt;
      byte_index_r     <= byte_index_nxt;
      expected_block_r <= expected_block_nxt;
      running_sum_r    <= running_sum_nxt;
      timeout_left_r   <= timeout_left_nxt;
      retries_left_r   <= retries_left_nxt;
      failure_count_r  <= failure_count_nxt;
      block_number_r   <= block_number_nxt;
      word_idx_r       <= word_idx_nxt;
    end
  end

  // Hold the parked reply
  always_ff @(posedge clk) begin
    pend_reply_r <= pend_reply_nxt;
    pend_end_r   <= pend_end_nxt;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_reload_r <= RST_TIMEOUT_RELOAD;
      start_retries_r  <= RST_START_RETRIES;
      packet_retries_r <= RST_PACKET_RETRIES;
      max_failures_r   <= RST_MAX_FAILURES;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_TIMEOUT_RELOAD: timeout_reload_r <= cfg_wdata;
        REG_START_RETRIES:  start_retries_r  <= cfg_wdata[7:0];
        REG_PACKET_RETRIES: packet_retries_r <= cfg_wdata[7:0];
        REG_MAX_FAILURES:   max_failures_r   <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  xmcr_payload_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .be    (ram_be),
    .waddr (data_pos[LANE_W +: WORD_AW]),
    .wdata ({WORD_BYTES{rx_b}}),
    .re    (ram_re),
    .raddr (word_idx_r),
    .rdata (ram_rdata)
  );

  xmcr_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .can_accept (can_accept),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_res)
  );

  assign out_tdata = {6'd0, out_res.session_end, out_res.reply_byte, out_res.data_word};
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.last;

endmodule

@@ tb/tb_xmodem_checksum_receiver.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the XMODEM checksum receiver: feeds start, tick and byte
// words, predicts payload and reply words, and checks the result stream word by word.
// Depends on xmcr_pkg and xmodem_checksum_receiver.
module tb_xmodem_checksum_receiver;
  import xmcr_pkg::*;

  localparam int SETTLE_CYCLES = 64;
  localparam int STALL_LIMIT   = 2000;
  localparam int LONG_HOLD     = 300;
  localparam int MAX_REPORTS   = 40;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] rx;
  } rx_word_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] rx_byte
  logic [1:0]  in_tuser;   // [1:0] op
  logic        out_tvalid;
  logic        out_tready;
  logic [79:0] out_tdata;  // [63:0] data_word, [71:64] reply_byte, [73:72] session_end
  logic        out_tuser;  // [0] kind
  logic        out_tlast;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [15:0] cfg_wdata;

  xmodem_checksum_receiver dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  rx_word_t     word_q[$];
  xmcr_result_t result_q[$];
  int           fail_count;
  int           idle_cycles;
  int           words_pushed;
  int           tx_gap;
  int           rx_gap;
  int           hold_left;
  bit           word_taken;
  bit           calm;
  bit           hold_req;
  logic [7:0]   gen_block;

  // Shadow copy of the receiver's registers and session state
  logic [15:0] sh_timeout_reload;
  logic [7:0]  sh_start_retries;
  logic [7:0]  sh_packet_retries;
  logic [7:0]  sh_max_failures;
  logic        sh_receiving;
  logic        sh_in_packet;
  logic [7:0]  sh_index;
  logic [7:0]  sh_expected;
  logic [7:0]  sh_sum;
  logic [7:0]  sh_block_no;
  logic [15:0] sh_timeout_left;
  logic [7:0]  sh_retries;
  logic [7:0]  sh_failures;
  logic [7:0]  sh_payload [PAYLOAD_BYTES];

  function automatic void clear_session();
    sh_receiving    = 1'b0;
    sh_in_packet    = 1'b0;
    sh_index        = '0;
    sh_expected     = '0;
    sh_sum          = '0;
    sh_block_no     = '0;
    sh_timeout_left = '0;
    sh_retries      = '0;
    sh_failures     = '0;
  endfunction

  function automatic void shadow_reset();
    sh_timeout_reload = RST_TIMEOUT_RELOAD;
    sh_start_retries  = RST_START_RETRIES;
    sh_packet_retries = RST_PACKET_RETRIES;
    sh_max_failures   = RST_MAX_FAILURES;
    clear_session();
    for (int i = 0; i < PAYLOAD_BYTES; i++) sh_payload[i] = '0;
  endfunction

  function automatic void shadow_config(logic [1:0] addr, logic [15:0] v);
    case (addr)
      REG_TIMEOUT_RELOAD: sh_timeout_reload = v;
      REG_START_RETRIES:  sh_start_retries  = v[7:0];
      REG_PACKET_RETRIES: sh_packet_retries = v[7:0];
      REG_MAX_FAILURES:   sh_max_failures   = v[7:0];
      default: ;
    endcase
  endfunction

  function automatic void expect_reply(logic [7:0] code, logic [1:0] fin);
    xmcr_result_t r;
    r = '0;
    r.kind        = KIND_REPLY;
    r.reply_byte  = code;
    r.session_end = fin;
    r.last        = 1'b1;
    result_q.push_back(r);
  endfunction

  // Sixteen payload words, first byte in the low lane
  function automatic void expect_payload();
    xmcr_result_t r;
    for (int w = 0; w < WORDS; w++) begin
      r = '0;
      r.kind = KIND_DATA;
      for (int j = 0; j < WORD_BYTES; j++)
        r.data_word[j*8 +: 8] = sh_payload[w*WORD_BYTES + j];
      result_q.push_back(r);
    end
  endfunction

  function automatic void predict_byte(logic [7:0] b);
    logic [7:0] idx;
    if (sh_in_packet) begin
      idx = sh_index;
      if (idx == IDX_BLOCK) begin
        sh_block_no = b;
      end else if (idx >= IDX_DATA_LO && idx < IDX_DATA_END) begin
        sh_payload[idx - IDX_DATA_LO] = b;
        sh_sum = sh_sum + b;
      end
      sh_index = idx + 8'd1;
      if (sh_index < PKT_LEN) return;
      // Checksum byte: judge the whole block
      sh_in_packet = 1'b0;
      sh_index     = '0;
      if (sh_block_no == sh_expected && sh_sum == b) begin
        expect_payload();
        sh_expected = sh_expected + 8'd1;
        sh_failures = '0;
        expect_reply(B_ACK, END_NONE);
      end else begin
        expect_reply(B_NAK, END_NONE);
      end
      return;
    end
    sh_index = '0;
    if (b == B_SOH) begin
      sh_in_packet    = 1'b1;
      sh_timeout_left = sh_timeout_reload;
      sh_retries      = sh_packet_retries;
      sh_sum          = '0;
    end else if (b == B_EOT || b == B_CAN) begin
      clear_session();
      expect_reply(B_ACK, END_DONE);
    end
  endfunction

  function automatic void predict_tick();
    if (sh_timeout_left != 0) begin
      sh_timeout_left = sh_timeout_left - 16'd1;
      return;
    end
    if (sh_failures != 8'd255) sh_failures = sh_failures + 8'd1;
    if (sh_failures >= sh_max_failures) begin
      clear_session();
      expect_reply(B_CAN, END_ABORT);
      return;
    end
    sh_timeout_left = sh_timeout_reload;
    if (sh_retries != 0) begin
      sh_retries = sh_retries - 8'd1;
    end else begin
      sh_receiving = 1'b0;
      sh_in_packet = 1'b0;
    end
  endfunction

  function automatic void predict_word(logic [1:0] op, logic [7:0] b);
    if (op == OP_START) begin
      sh_receiving    = 1'b1;
      sh_timeout_left = sh_timeout_reload;
      sh_retries      = sh_start_retries;
      sh_expected     = 8'd1;
      return;
    end
    if (!sh_receiving) return;
    if (op == OP_BYTE) predict_byte(b);
    else if (op == OP_TICK) predict_tick();
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  function automatic void push_word(logic [1:0] op, logic [7:0] rx);
    rx_word_t w;
    w.op = op;
    w.rx = rx;
    word_q.push_back(w);
    words_pushed++;
  endfunction

  function automatic void push_ticks(int n);
    repeat (n) push_word(OP_TICK, 8'($urandom));
  endfunction

  // SOH, block number, complement (sometimes a random byte), payload and checksum
  function automatic void push_packet(logic [7:0] blk, bit bad_sum, bit alt_fill);
    logic [7:0] sum;
    logic [7:0] b;
    sum = '0;
    push_word(OP_BYTE, B_SOH);
    push_word(OP_BYTE, blk);
    push_word(OP_BYTE, ($urandom_range(3, 0) == 0) ? 8'($urandom) : ~blk);
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      b = alt_fill ? ((i % 2 == 1) ? 8'hFF : 8'h00) : 8'($urandom);
      sum = sum + b;
      push_word(OP_BYTE, b);
    end
    push_word(OP_BYTE, bad_sum ? (sum ^ 8'($urandom_range(255, 1))) : sum);
  endfunction

  // Start, an optional whole block of random kind, then at least n words of short events
  function automatic void random_run(int n, bit with_packet);
    int stop;
    int pick;
    push_word(OP_START, 8'($urandom));
    gen_block = 8'd1;
    if (with_packet) begin
      pick = $urandom_range(2, 0);
      if (pick == 0) begin
        push_packet(gen_block, 1'b0, 1'b0);
        gen_block = gen_block + 8'd1;
      end else if (pick == 1) begin
        push_packet(gen_block + 8'($urandom_range(255, 1)), 1'b0, 1'b0);
      end else begin
        push_packet(gen_block, 1'b1, 1'b0);
      end
    end
    stop = words_pushed + n;
    while (words_pushed < stop) begin
      pick = $urandom_range(99, 0);
      if (pick < 10) begin
        push_word(OP_START, 8'($urandom));
        gen_block = 8'd1;
      end else if (pick < 25) begin
        // cut-off block: later words fall into it
        push_word(OP_BYTE, B_SOH);
        repeat ($urandom_range(8, 0)) push_word(OP_BYTE, 8'($urandom));
      end else if (pick < 50) begin
        push_ticks($urandom_range(4, 1));
      end else if (pick < 75) begin
        push_word(OP_BYTE, 8'($urandom));
      end else if (pick < 90) begin
        push_word(OP_BYTE, pick[0] ? B_EOT : B_CAN);
        push_word(OP_START, 8'($urandom));
        gen_block = 8'd1;
      end else begin
        push_word(OP_UNUSED, 8'($urandom));
      end
    end
  endfunction

  task automatic write_reg(logic [1:0] addr, logic [15:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_config();
    write_reg(REG_TIMEOUT_RELOAD, 16'($urandom_range(40, 2)));
    write_reg(REG_START_RETRIES, 16'($urandom_range(20, 0)));
    write_reg(REG_PACKET_RETRIES, 16'($urandom_range(20, 0)));
    write_reg(REG_MAX_FAILURES, 16'($urandom_range(12, 1)));
  endtask

  // Wait for every queued word to go and every expected word to arrive
  task automatic settle();
    while (word_q.size() != 0 || in_tvalid || result_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Sample both handshakes, predict, check and watch for a stall
  always @(posedge clk) begin : monitor
    xmcr_result_t want;
    if (!rst_n) begin
      word_taken = 1'b0;
    end else begin
      word_taken = in_tvalid && in_tready;
      if (cfg_we) shadow_config(cfg_addr, cfg_wdata);
      if (word_taken) predict_word(in_tuser, in_tdata);
      if (out_tvalid && out_tready) begin
        if (result_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: unexpected word, expected none, actual kind %0h tdata %0h last %0h",
                     $time, out_tuser, out_tdata, out_tlast);
        end else begin
          want = result_q.pop_front();
          check_field("kind", want.kind, out_tuser);
          check_field("data_word", want.data_word, out_tdata[63:0]);
          check_field("reply_byte", want.reply_byte, out_tdata[71:64]);
          check_field("session_end", want.session_end, out_tdata[73:72]);
          check_field("padding", '0, out_tdata[79:74]);
          check_field("last", want.last, out_tlast);
        end
      end
      if (word_taken || (out_tvalid && out_tready) || cfg_we) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Input side: hold the word until taken, idle in random bursts
  always @(negedge clk) begin : feed
    rx_word_t w;
    if (rst_n && !(in_tvalid && !word_taken)) begin
      if (tx_gap != 0) begin
        tx_gap--;
        in_tvalid <= 1'b0;
      end else if (!calm && $urandom_range(7, 0) == 0) begin
        tx_gap = $urandom_range(15, 0);
        in_tvalid <= 1'b0;
      end else if (word_q.size() != 0) begin
        w = word_q.pop_front();
        in_tuser  <= w.op;
        in_tdata  <= w.rx;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result side: random stall bursts, plus one long hold on request
  always @(negedge clk) begin : sink
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = LONG_HOLD - 1;
      out_tready <= 1'b0;
    end else if (rx_gap != 0) begin
      rx_gap--;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(7, 0) == 0) begin
      rx_gap = $urandom_range(15, 0);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  initial begin : stimulus
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = '0;
    out_tready   = 1'b0;
    cfg_we       = 1'b0;
    cfg_addr     = '0;
    cfg_wdata    = '0;
    calm         = 1'b0;
    hold_req     = 1'b0;
    tx_gap       = 0;
    rx_gap       = 0;
    hold_left    = 0;
    fail_count   = 0;
    idle_cycles  = 0;
    words_pushed = 0;
    word_taken   = 1'b0;
    gen_block    = 8'd1;
    shadow_reset();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset defaults: ignored words while idle, then one good block
    push_word(OP_BYTE, B_SOH);
    push_word(OP_TICK, 8'hFF);
    push_word(OP_UNUSED, 8'hFF);
    push_word(OP_START, 8'h00);
    push_word(OP_BYTE, 8'h00);
    push_word(OP_BYTE, 8'hFF);
    push_word(OP_UNUSED, B_EOT);
    push_packet(8'd1, 1'b0, 1'b1);
    push_ticks(3);
    push_word(OP_BYTE, B_EOT);
    push_word(OP_START, 8'h5A);
    push_word(OP_BYTE, B_CAN);
    // stall the result side as the good block's checksum goes in
    while (word_q.size() > 6) @(posedge clk);
    hold_req = 1'b1;
    settle();

    // Zero timeout and no retries: each tick in a session expires and drops it
    write_reg(REG_TIMEOUT_RELOAD, 16'd0);
    write_reg(REG_START_RETRIES, 16'd0);
    write_reg(REG_PACKET_RETRIES, 16'hAB00);
    write_reg(REG_MAX_FAILURES, 16'd255);
    push_word(OP_START, 8'h00);
    push_ticks(2);
    push_word(OP_BYTE, B_EOT);
    push_word(OP_START, 8'h00);
    push_word(OP_BYTE, B_SOH);
    push_word(OP_BYTE, 8'd1);
    push_ticks(1);
    push_word(OP_START, 8'h00);
    push_word(OP_BYTE, B_EOT);
    settle();

    // Zero failure limit aborts on the first expiry, then a limit of one
    write_reg(REG_MAX_FAILURES, 16'd0);
    push_word(OP_START, 8'h00);
    push_ticks(1);
    settle();
    write_reg(REG_MAX_FAILURES, 16'd1);
    write_reg(REG_TIMEOUT_RELOAD, 16'd3);
    push_word(OP_START, 8'h00);
    push_ticks(4);
    settle();

    // Run out of retries, restart with the failure count kept, then abort
    write_reg(REG_TIMEOUT_RELOAD, 16'd0);
    write_reg(REG_START_RETRIES, 16'd2);
    write_reg(REG_PACKET_RETRIES, 16'hAB05);
    write_reg(REG_MAX_FAILURES, 16'd5);
    push_word(OP_START, 8'h00);
    push_ticks(4);
    push_word(OP_START, 8'h00);
    push_ticks(2);
    settle();

    // Random traffic under random settings
    random_config();
    random_run(12, 1'b1);
    settle();

    // Last stretch without idling on either side
    calm = 1'b1;
    random_config();
    random_run(12, 1'b0);
    settle();

    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
